// ===== rtl/etp_pkg.sv =====
// Package for the EDT shaper and token policer.
// Holds shared widths, constants, state types and the arithmetic unit request.
// No dependencies.
package etp_pkg;

    localparam int unsigned LEN_W     = 16;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned CFG_W     = 40;
    localparam int unsigned RATE_W    = CFG_W - 3;
    localparam int unsigned MPLIER_W  = 30;
    localparam int unsigned ACC_W     = RATE_W + MPLIER_W;
    localparam int unsigned CNT_W     = 7;

    localparam logic [CFG_W-1:0]    HORIZON_RST = 40'd2000000000;
    localparam logic [TIME_W-1:0]   NS_PER_SEC  = 64'd1000000000;

    typedef enum logic [1:0] {
        REG_EGRESS_RATE  = 2'd0,
        REG_INGRESS_RATE = 2'd1,
        REG_DROP_HORIZON = 2'd2,
        REG_NONE         = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CALC,
        ST_FIN1,
        ST_FIN2
    } etp_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_DIV
    } md_phase_t;

    typedef struct packed {
        logic                start;
        logic [RATE_W-1:0]   mcand;
        logic [MPLIER_W-1:0] mplier;
        logic [RATE_W-1:0]   divisor;
    } md_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quot;
    } md_rsp_t;

endpackage

// ===== rtl/etp_muldiv.sv =====
// Bit-serial multiply then divide unit: quot = (mcand * mplier) / divisor.
// One multiplier bit per cycle, then one quotient bit per cycle (restoring).
// Depends on etp_pkg.
module etp_muldiv
    import etp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    md_phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RATE_W-1:0]   mcand_reg, mcand_next;
    logic [MPLIER_W-1:0] mplier_reg, mplier_next;
    logic [RATE_W-1:0]   divisor_reg, divisor_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic                done_reg, done_next;
    logic [RATE_W:0]     trial;
    logic                fits;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MPLIER_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

    assign trial = {rem_reg, acc_reg[ACC_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    // Phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                    phase_next = PH_MUL;
            end
            PH_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                    phase_next = PH_DIV;
            end
            PH_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Shift and add, then shift and subtract
    always_comb
    begin
        cnt_next     = cnt_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        divisor_next = divisor_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        done_next    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next   = req.mcand;
                    mplier_next  = req.mplier;
                    divisor_next = req.divisor;
                    acc_next     = '0;
                    cnt_next     = '0;
                end
            end
            PH_MUL:
            begin
                acc_next    = {acc_reg[ACC_W-2:0], 1'b0}
                              + (mplier_reg[MPLIER_W-1] ? ACC_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[MPLIER_W-2:0], 1'b0};
                rem_next    = '0;
                cnt_next    = (cnt_reg == MUL_LAST) ? '0 : cnt_reg + 1'b1;
            end
            PH_DIV:
            begin
                rem_next  = fits ? RATE_W'(trial - {1'b0, divisor_reg}) : trial[RATE_W-1:0];
                acc_next  = {acc_reg[ACC_W-2:0], fits};
                cnt_next  = cnt_reg + 1'b1;
                done_next = (cnt_reg == DIV_LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        divisor_reg <= divisor_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg;

endmodule

// ===== rtl/edt_shaper_token_policer.sv =====
// Top level of the EDT shaper and token policer for one subscriber.
// Depends on etp_pkg and etp_muldiv.
//
// Usage: one request on the s_ side is one packet; one result on the m_ side
// gives its verdict. s_tuser carries the direction (1 egress, 0 ingress).
// Egress packets get a departure slot from the last slot plus
// length * 1e9 / byte rate; ingress packets draw on a token bucket refilled
// by rate * elapsed / 1e9. Both products and quotients come from one shared
// bit-serial unit, which multiplies first and then divides.
// A computed packet passes through setup, the serial unit and two finishing
// steps before its result; setup goes straight to the final step when the
// direction's rate is below 8 bps or when ingress needs no refill arithmetic.
// One packet is worked on at a time: the next request is not accepted until
// the current packet has left its final step.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the block holds the next result in its
// final step and commits no state until that result is taken.
// Reset clears the rates and all subscriber state, and sets the drop horizon
// to 2 s. Configuration is written through cfg_we / cfg_index / cfg_data
// by the user only while the block is idle; the block does not enforce it.
module edt_shaper_token_policer
    import etp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] packet_length, [79:16] now_ns, [143:80] requested_departure_ns
    input  logic [143:0]          s_tdata,
    // [0] is_egress
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] departure_ns
    output logic [TIME_W-1:0]     m_tdata,
    // [0] drop, [1] stamp_valid
    output logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    etp_state_t state_reg, state_next;

    logic [CFG_W-1:0]  erate_reg, irate_reg, horizon_reg;
    logic [TIME_W-1:0] last_slot_reg, last_slot_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [CFG_W-1:0]  tokens_reg, tokens_next;

    logic              egr_reg, egr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] rq_reg, rq_next;
    logic [TIME_W-1:0] base_reg, base_next;
    logic [TIME_W-1:0] slot_reg, slot_next;
    logic [CFG_W-1:0]  tmp_reg, tmp_next;
    logic              bypass_reg, bypass_next;

    logic              ovalid_reg, ovalid_next;
    logic              odrop_reg, odrop_next;
    logic              ostamp_reg, ostamp_next;
    logic [TIME_W-1:0] odep_reg, odep_next;

    logic [RATE_W-1:0] rate_e, rate_i;
    logic [TIME_W-1:0] elapsed;
    logic [CFG_W:0]    tok_sum;
    logic              out_free;
    logic              accept;
    md_req_t           md_req;
    md_rsp_t           md_rsp;

    assign rate_e   = erate_reg[CFG_W-1:3];
    assign rate_i   = irate_reg[CFG_W-1:3];
    assign elapsed  = now_reg - last_time_reg;
    assign tok_sum  = {1'b0, tokens_reg} + (CFG_W+1)'(md_rsp.quot[RATE_W-1:0]);
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    etp_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erate_reg   <= '0;
            irate_reg   <= '0;
            horizon_reg <= HORIZON_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_EGRESS_RATE:  erate_reg   <= cfg_data;
                REG_INGRESS_RATE: irate_reg   <= cfg_data;
                REG_DROP_HORIZON: horizon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (egr_reg)
                    state_next = (rate_e == '0) ? ST_FIN2 : ST_CALC;
                else if (rate_i == '0 || elapsed == '0 || elapsed >= NS_PER_SEC)
                    state_next = ST_FIN2;
                else
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (md_rsp.done)
                    state_next = ST_FIN1;
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        egr_next       = egr_reg;
        len_next       = len_reg;
        now_next       = now_reg;
        rq_next        = rq_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        tmp_next       = tmp_reg;
        bypass_next    = bypass_reg;
        last_slot_next = last_slot_reg;
        last_time_next = last_time_reg;
        tokens_next    = tokens_reg;
        ovalid_next    = ovalid_reg && !m_tready;
        odrop_next     = odrop_reg;
        ostamp_next    = ostamp_reg;
        odep_next      = odep_reg;
        md_req         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    egr_next = s_tuser;
                    len_next = s_tdata[15:0];
                    now_next = s_tdata[79:16];
                    rq_next  = s_tdata[143:80];
                end
            end
            ST_SETUP:
            begin
                base_next   = (rq_reg < now_reg) ? now_reg : rq_reg;
                bypass_next = 1'b0;
                tmp_next    = tokens_reg;
                if (egr_reg)
                begin
                    bypass_next    = (rate_e == '0);
                    md_req.start   = (rate_e != '0);
                    md_req.mcand   = RATE_W'(NS_PER_SEC);
                    md_req.mplier  = MPLIER_W'(len_reg);
                    md_req.divisor = rate_e;
                end
                else if (rate_i == '0)
                    bypass_next = 1'b1;
                else if (elapsed >= NS_PER_SEC)
                    tmp_next = CFG_W'(rate_i);
                else if (elapsed != '0)
                begin
                    md_req.start   = 1'b1;
                    md_req.mcand   = rate_i;
                    md_req.mplier  = elapsed[MPLIER_W-1:0];
                    md_req.divisor = RATE_W'(NS_PER_SEC);
                end
            end
            ST_FIN1:
            begin
                // slot from last slot plus serial delay, or capped refill
                slot_next = last_slot_reg + md_rsp.quot[TIME_W-1:0];
                tmp_next  = (tok_sum > (CFG_W+1)'(rate_i)) ? CFG_W'(rate_i)
                                                           : tok_sum[CFG_W-1:0];
            end
            ST_FIN2:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odrop_next  = 1'b0;
                    ostamp_next = 1'b0;
                    odep_next   = '0;
                    if (bypass_reg)
                        ;
                    else if (egr_reg)
                    begin
                        if (slot_reg <= base_reg)
                            last_slot_next = base_reg;
                        else if ((slot_reg - now_reg) >= TIME_W'(horizon_reg))
                            odrop_next = 1'b1;
                        else
                        begin
                            last_slot_next = slot_reg;
                            ostamp_next    = 1'b1;
                            odep_next      = slot_reg;
                        end
                    end
                    else
                    begin
                        last_time_next = now_reg;
                        if (tmp_reg >= CFG_W'(len_reg))
                            tokens_next = tmp_reg - CFG_W'(len_reg);
                        else
                        begin
                            tokens_next = tmp_reg;
                            odrop_next  = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovalid_reg    <= 1'b0;
            last_slot_reg <= '0;
            last_time_reg <= '0;
            tokens_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ovalid_reg    <= ovalid_next;
            last_slot_reg <= last_slot_next;
            last_time_reg <= last_time_next;
            tokens_reg    <= tokens_next;
        end
    end

    always_ff @(posedge clk)
    begin
        egr_reg    <= egr_next;
        len_reg    <= len_next;
        now_reg    <= now_next;
        rq_reg     <= rq_next;
        base_reg   <= base_next;
        slot_reg   <= slot_next;
        tmp_reg    <= tmp_next;
        bypass_reg <= bypass_next;
        odrop_reg  <= odrop_next;
        ostamp_reg <= ostamp_next;
        odep_reg   <= odep_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odep_reg;
    assign m_tuser  = {ostamp_reg, odrop_reg};

    // A request is always followed by the setup step
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SETUP)
        else $error("accepted request did not enter setup");

    // The serial unit only finishes while the controller waits for it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == ST_CALC)
        else $error("serial unit finished outside calc");

    // A result is never both dropped and stamped
    a_drop_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both dropped and stamped");

    // A new result only appears out of the final step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FIN2)
        else $error("result loaded outside final step");

endmodule
